@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every rising clk edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// check prop on every rising clk edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

@@ sv/crl_pkg.sv @@
// ---------------------------------------------------------------------------
// crl_pkg
// Widths, register indexes and shared types of the combing residual limiter.
// ---------------------------------------------------------------------------
`default_nettype none

package crl_pkg;

    localparam int PIX_W      = 8;
    localparam int STRENGTH_W = 15;
    localparam int SCALE_W    = 12;
    localparam int AMOUNT_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int S_DATA_W   = 3 * PIX_W;
    localparam int M_DATA_W   = PIX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHANGE = 2'd2;

    localparam logic [STRENGTH_W-1:0] STRENGTH_RST   = 15'd691;
    localparam logic [SCALE_W-1:0]    SCALE_RST      = 12'd64;
    localparam logic [AMOUNT_W-1:0]   MAX_CHANGE_RST = 8'd255;

    typedef struct packed {
        logic [STRENGTH_W-1:0] strength_q8;
        logic [SCALE_W-1:0]    scale_q8;
        logic [AMOUNT_W-1:0]   max_change;
    } crl_cfg_t;

endpackage

`default_nettype wire

@@ sv/crl_pipe.sv @@
// ---------------------------------------------------------------------------
// crl_pipe
// Five-stage datapath: differences, strength product, selection, scale
// product, correction sum and clamp. All stages advance on one enable.
// ---------------------------------------------------------------------------
`default_nettype none

module crl_pipe (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  crl_pkg::crl_cfg_t                   cfg,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [crl_pkg::PIX_W-1:0]           src_pixel,
    input  wire  [crl_pkg::PIX_W-1:0]           light_pixel,
    input  wire  [crl_pkg::PIX_W-1:0]           strong_pixel,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [crl_pkg::PIX_W-1:0]           out_pixel
);
    import crl_pkg::*;

    localparam int TMAG_W = PIX_W + STRENGTH_W;
    localparam int SEL_W  = 2 * PIX_W;
    localparam int PROD_W = SEL_W + SCALE_W;
    localparam int CORR_W = SCALE_W;
    localparam int SUM_W  = CORR_W + 2;
    localparam int LIM_W  = PIX_W + 2;

    logic en;

    // stage A
    logic             a_valid_reg;
    logic [PIX_W-1:0] a_src_reg, a_light_reg, a_d1_mag_reg, a_ls_mag_reg;
    logic             a_d1_neg_reg, a_ls_neg_reg;
    logic [PIX_W:0]   d1_diff, ls_diff;
    logic [PIX_W-1:0] d1_mag_next, ls_mag_next;

    // stage B
    logic              b_valid_reg;
    logic [PIX_W-1:0]  b_src_reg, b_light_reg, b_d1_mag_reg;
    logic              b_d1_neg_reg, b_t_neg_reg;
    logic [TMAG_W-1:0] b_t_mag_reg;

    // stage C
    logic              c_valid_reg;
    logic [PIX_W-1:0]  c_src_reg, c_light_reg;
    logic [SEL_W-1:0]  c_sel_mag_reg, sel_mag_next;
    logic              c_neg_reg, c_opp_reg, neg_next, opp_next, take_d1;
    logic [SEL_W-1:0]  d1q_mag;
    logic              d1_nz, t_nz;

    // stage D
    logic              d_valid_reg;
    logic [PIX_W-1:0]  d_src_reg, d_light_reg;
    logic [CORR_W-1:0] d_corr_reg, corr_next;
    logic              d_neg_reg;
    logic [PROD_W-1:0] scale_prod;

    // stage E (output)
    logic              m_valid_reg;
    logic [PIX_W-1:0]  m_pixel_reg, pixel_next;
    logic signed [SUM_W-1:0] sum, mag_s, lo_s, hi_s, clamp1, clamp2;
    logic signed [LIM_W-1:0] lo, hi;

    assign en       = !m_valid_reg || out_ready;
    assign in_ready = en;

    // stage A: differences as sign and magnitude
    always_comb begin
        d1_diff     = {1'b0, src_pixel} - {1'b0, light_pixel};
        ls_diff     = {1'b0, light_pixel} - {1'b0, strong_pixel};
        d1_mag_next = d1_diff[PIX_W] ? PIX_W'(-d1_diff) : d1_diff[PIX_W-1:0];
        ls_mag_next = ls_diff[PIX_W] ? PIX_W'(-ls_diff) : ls_diff[PIX_W-1:0];
    end

    // stage C: pick smaller magnitude, detect opposite signs
    always_comb begin
        d1q_mag      = {b_d1_mag_reg, {PIX_W{1'b0}}};
        d1_nz        = (b_d1_mag_reg != '0);
        t_nz         = (b_t_mag_reg != '0);
        take_d1      = {{(TMAG_W-SEL_W){1'b0}}, d1q_mag} < b_t_mag_reg;
        sel_mag_next = take_d1 ? d1q_mag : b_t_mag_reg[SEL_W-1:0];
        neg_next     = take_d1 ? b_d1_neg_reg : (b_t_neg_reg && t_nz);
        opp_next     = d1_nz && t_nz && (b_d1_neg_reg != b_t_neg_reg);
    end

    // stage D: scale or truncate to integer
    always_comb begin
        scale_prod = PROD_W'(c_sel_mag_reg) * PROD_W'(cfg.scale_q8);
        if (c_opp_reg) begin
            corr_next = scale_prod[PROD_W-1:SEL_W];
        end else begin
            corr_next = {{(CORR_W-PIX_W){1'b0}}, c_sel_mag_reg[SEL_W-1:PIX_W]};
        end
    end

    // stage E: add correction, clamp around source, clamp to pixel range
    always_comb begin
        mag_s  = $signed({2'b00, d_corr_reg});
        sum    = $signed({{(SUM_W-PIX_W){1'b0}}, d_light_reg})
                 + (d_neg_reg ? -mag_s : mag_s);
        lo     = $signed({2'b00, d_src_reg}) - $signed({2'b00, cfg.max_change});
        hi     = $signed({2'b00, d_src_reg}) + $signed({2'b00, cfg.max_change});
        lo_s   = SUM_W'(lo);
        hi_s   = SUM_W'(hi);
        clamp1 = (sum < lo_s) ? lo_s : sum;
        clamp2 = (clamp1 > hi_s) ? hi_s : clamp1;
        if (clamp2 < 0) begin
            pixel_next = '0;
        end else if (clamp2 > $signed(SUM_W'(255))) begin
            pixel_next = '1;
        end else begin
            pixel_next = clamp2[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            m_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_src_reg     <= src_pixel;
            a_light_reg   <= light_pixel;
            a_d1_mag_reg  <= d1_mag_next;
            a_d1_neg_reg  <= d1_diff[PIX_W];
            a_ls_mag_reg  <= ls_mag_next;
            a_ls_neg_reg  <= ls_diff[PIX_W];

            b_src_reg     <= a_src_reg;
            b_light_reg   <= a_light_reg;
            b_d1_mag_reg  <= a_d1_mag_reg;
            b_d1_neg_reg  <= a_d1_neg_reg;
            b_t_neg_reg   <= a_ls_neg_reg;
            b_t_mag_reg   <= TMAG_W'(a_ls_mag_reg) * TMAG_W'(cfg.strength_q8);

            c_src_reg     <= b_src_reg;
            c_light_reg   <= b_light_reg;
            c_sel_mag_reg <= sel_mag_next;
            c_neg_reg     <= neg_next;
            c_opp_reg     <= opp_next;

            d_src_reg     <= c_src_reg;
            d_light_reg   <= c_light_reg;
            d_corr_reg    <= corr_next;
            d_neg_reg     <= c_neg_reg;

            m_pixel_reg   <= pixel_next;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_pixel = m_pixel_reg;

endmodule

`default_nettype wire

@@ sv/combing_residual_limiter_unit.sv @@
// ---------------------------------------------------------------------------
// combing_residual_limiter_unit
// Per-pixel residual limiter for vertical comb removal on a pixel stream.
// ---------------------------------------------------------------------------
// The block takes one word per clock while the output is not stalled and
// returns one limited pixel per word. The datapath has five register stages
// (differences, strength product, selection, scale product, sum and clamp)
// and passes one pixel per clock when m_tready does not stall it. A stall on
// m_tready freezes the whole pipeline and deasserts
// s_tready in the same cycle. Registers are written through the cfg port,
// which is always ready; write them only while no pixel is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module combing_residual_limiter_unit (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [crl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [crl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // source_pixel[7:0], light_blur_pixel[15:8], strong_blur_pixel[23:16]
    input  wire  [crl_pkg::S_DATA_W-1:0]         s_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // output_pixel[7:0]
    output logic [crl_pkg::M_DATA_W-1:0]         m_tdata
);
    import crl_pkg::*;

    crl_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.strength_q8 <= STRENGTH_RST;
            cfg_reg.scale_q8    <= SCALE_RST;
            cfg_reg.max_change  <= MAX_CHANGE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STRENGTH: begin
                    cfg_reg.strength_q8 <= cfg_data[STRENGTH_W-1:0];
                end
                CFG_SCALE: begin
                    cfg_reg.scale_q8 <= cfg_data[SCALE_W-1:0];
                end
                CFG_MAX_CHANGE: begin
                    cfg_reg.max_change <= cfg_data[AMOUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    crl_pipe u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .src_pixel    (s_tdata[PIX_W-1:0]),
        .light_pixel  (s_tdata[2*PIX_W-1:PIX_W]),
        .strong_pixel (s_tdata[3*PIX_W-1:2*PIX_W]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_pixel    (m_tdata)
    );

endmodule

`default_nettype wire

@@ sv/crl_checker.sv @@
// ---------------------------------------------------------------------------
// crl_checker
// Port-level checks of the combing residual limiter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crl_checker (
    input wire                                 aclk,
    input wire                                 aresetn,
    input wire                                 s_tready,
    input wire                                 m_tvalid,
    input wire                                 m_tready,
    input wire [crl_pkg::M_DATA_W-1:0]         m_tdata
);

    // hold a stalled word
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // take no word while the output is blocked
    `ASSERT_CLK(a_stall_blocks_in, aclk, aresetn, m_tvalid && !m_tready |-> !s_tready)

    // never throttle the input while the output drains
    `ASSERT_CLK(a_drain_opens_in, aclk, aresetn, m_tready |-> s_tready)

    // show no word in the cycle after reset
    `ASSERT_CLK(a_quiet_after_reset, aclk, aresetn, !$past(aresetn) |-> !m_tvalid)

endmodule

bind combing_residual_limiter_unit crl_checker u_crl_checker (.*);

`default_nettype wire
